// File: hw/rtl/blscc_pkg.sv
// ----------------------------------------------------------------------------
// blscc_pkg
// Shared types and constants for the battery level scan and charge control
// unit.
// ----------------------------------------------------------------------------
package blscc_pkg;

	// Field widths
	localparam int unsigned PROBE_W = 3;
	localparam int unsigned LEVEL_W = 3;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned CFG_W   = 8;
	localparam int unsigned IDX_W   = 1;

	// Threshold probes, 4.2V down to 2.8V
	localparam logic [PROBE_W-1:0] PROBE_TOP    = 3'd0;
	localparam logic [PROBE_W-1:0] PROBE_LOWEST = 3'd4;
	localparam logic [PROBE_W-1:0] PROBE_COUNT  = 3'd5;

	// Latched levels
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_80MA  = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH_LO = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH_HI = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 3'd5;

	// Charge modes
	localparam logic [MODE_W-1:0] MODE_OFF          = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TRICKLE      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HIGH         = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HIGH_REDUCED = 3'd3;
	localparam logic [MODE_W-1:0] MODE_80MA         = 3'd4;

	// Item kinds
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Configuration register indexes and reset values
	localparam logic [IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 1'b0;
	localparam logic [IDX_W-1:0] CFG_QUALIFY_TICKS  = 1'b1;
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd250;
	localparam logic [CFG_W-1:0] QUALIFY_RESET  = 8'd200;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

	typedef struct packed {
		logic action;
		logic below_threshold;
		logic charger_present;
		logic temp_high;
	} item_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [PROBE_W-1:0] probe_index;
		logic [LEVEL_W-1:0] battery_level;
		logic               low_battery;
		logic [MODE_W-1:0]  charge_mode;
		logic               full_flag;
		logic               charge_qualified;
	} result_t;

endpackage

// File: hw/rtl/blscc_core.sv
// ----------------------------------------------------------------------------
// blscc_core
// Scan and charge state with its single-pass update. Presents the state as
// it stands after the item at the inputs, and commits it when the item is
// accepted.
// ----------------------------------------------------------------------------
module blscc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  blscc_pkg::item_t    item,
	input  blscc_pkg::cfg_wr_t  cfg_wr,
	output blscc_pkg::result_t  res_next
);

	logic [blscc_pkg::CFG_W-1:0]   debounce_q, qualify_ticks_q;
	logic [blscc_pkg::PROBE_W-1:0] probe_q, probe_n;
	logic [blscc_pkg::LEVEL_W-1:0] last_q, last_n;
	logic [blscc_pkg::COUNT_W-1:0] match_q, match_n, match_inc;
	logic [blscc_pkg::LEVEL_W-1:0] level_q, level_n;
	logic                          low_q, low_n;
	logic                          full_q, full_n;
	logic                          qual_q, qual_n;
	logic [blscc_pkg::COUNT_W-1:0] qcount_q, qcount_n, qcount_inc;
	logic [blscc_pkg::MODE_W-1:0]  mode_q, mode_n;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= blscc_pkg::DEBOUNCE_RESET;
			qualify_ticks_q <= blscc_pkg::QUALIFY_RESET;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				blscc_pkg::CFG_DEBOUNCE_LIMIT: debounce_q      <= cfg_wr.data;
				blscc_pkg::CFG_QUALIFY_TICKS:  qualify_ticks_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// Saturating match count and wrapping qualify count
	assign match_inc  = (match_q == blscc_pkg::COUNT_MAX) ? match_q : match_q + 1'b1;
	assign qcount_inc = qcount_q + 1'b1;

	// Compute the state after this item
	always_comb begin
		probe_n  = probe_q;
		last_n   = last_q;
		match_n  = match_q;
		level_n  = level_q;
		low_n    = low_q;
		full_n   = full_q;
		qual_n   = qual_q;
		qcount_n = qcount_q;
		mode_n   = mode_q;

		if (item.action == blscc_pkg::ACT_SAMPLE) begin
			// Hold on a reached threshold, step down on a miss
			if (!item.below_threshold) begin
				match_n = (probe_q == last_q) ? match_inc : '0;
				last_n  = probe_q;
			end else if (probe_q == blscc_pkg::PROBE_LOWEST) begin
				match_n = match_inc;
				last_n  = blscc_pkg::LEVEL_EMPTY;
			end else begin
				match_n = '0;
				probe_n = probe_q + 1'b1;
			end
			if (probe_n >= blscc_pkg::PROBE_COUNT)
				probe_n = blscc_pkg::PROBE_TOP;
			// Latch the level after a long enough run
			if (match_n >= debounce_q) begin
				probe_n = blscc_pkg::PROBE_TOP;
				match_n = '0;
				level_n = last_n;
				low_n   = (last_n == blscc_pkg::LEVEL_EMPTY);
			end
		end else if (!item.charger_present) begin
			// Drop all charge state when the charger leaves
			mode_n   = blscc_pkg::MODE_OFF;
			full_n   = 1'b0;
			qual_n   = 1'b0;
			qcount_n = '0;
		end else if (full_q) begin
			qcount_n = '0;
		end else begin
			// Count qualifying ticks
			qcount_n = qcount_inc;
			if (qcount_inc == qualify_ticks_q) begin
				qual_n   = 1'b1;
				qcount_n = '0;
			end
			// Pick the charge mode from the latched level
			if (qual_n) begin
				low_n = 1'b0;
				case (level_q) inside
					blscc_pkg::LEVEL_FULL: begin
						full_n = 1'b1;
						mode_n = blscc_pkg::MODE_OFF;
					end
					blscc_pkg::LEVEL_80MA: mode_n = blscc_pkg::MODE_80MA;
					blscc_pkg::LEVEL_HIGH_LO, blscc_pkg::LEVEL_HIGH_HI: begin
						mode_n = item.temp_high ? blscc_pkg::MODE_HIGH_REDUCED
						                        : blscc_pkg::MODE_HIGH;
					end
					blscc_pkg::LEVEL_LOW, blscc_pkg::LEVEL_EMPTY:
						mode_n = blscc_pkg::MODE_TRICKLE;
					default: ;
				endcase
			end
		end
	end

	// Commit the state on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q  <= '0;
			last_q   <= '0;
			match_q  <= '0;
			level_q  <= '0;
			low_q    <= 1'b0;
			full_q   <= 1'b0;
			qual_q   <= 1'b0;
			qcount_q <= '0;
			mode_q   <= blscc_pkg::MODE_OFF;
		end else if (take) begin
			probe_q  <= probe_n;
			last_q   <= last_n;
			match_q  <= match_n;
			level_q  <= level_n;
			low_q    <= low_n;
			full_q   <= full_n;
			qual_q   <= qual_n;
			qcount_q <= qcount_n;
			mode_q   <= mode_n;
		end
	end

	assign res_next.probe_index      = probe_n;
	assign res_next.battery_level    = level_n;
	assign res_next.low_battery      = low_n;
	assign res_next.charge_mode      = mode_n;
	assign res_next.full_flag        = full_n;
	assign res_next.charge_qualified = qual_n;

endmodule

// File: hw/rtl/battery_level_scan_charge_control_unit.sv
// ----------------------------------------------------------------------------
// battery_level_scan_charge_control_unit
// Battery level scanner and charge controller with a two-entry result queue.
// ----------------------------------------------------------------------------
// Each accepted item (a comparator sample or a charge tick) updates the state
// in the cycle it is accepted, and its result is written into the result
// queue at that clock edge; one item per cycle is sustained while the queue
// is not full. The queue holds two entries, so one finished result may wait
// for out_ready while the next item is still taken; in_ready drops only when
// both entries are full. Configuration writes are taken at any cycle
// (cfg_ready is always high) and should be issued while no item is in flight.
module battery_level_scan_charge_control_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        below_threshold,
	input  logic        charger_present,
	input  logic        temp_high,
	// Result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  probe_index,
	output logic [2:0]  battery_level,
	output logic        low_battery,
	output logic [2:0]  charge_mode,
	output logic        full_flag,
	output logic        charge_qualified
);

	blscc_pkg::item_t   item;
	blscc_pkg::cfg_wr_t cfg_wr;
	blscc_pkg::result_t res_next;
	blscc_pkg::result_t res_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               take, give;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = '{valid: cfg_valid, index: cfg_index, data: cfg_data};
	assign item      = '{action: action, below_threshold: below_threshold,
	                     charger_present: charger_present, temp_high: temp_high};

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign take      = in_valid && in_ready;
	assign give      = out_valid && out_ready;

	blscc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.cfg_wr   (cfg_wr),
		.res_next (res_next)
	);

	// Hold results in the queue
	always_ff @(posedge clk) begin
		if (take)
			res_q[wr_ptr_q] <= res_next;
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (take)
				wr_ptr_q <= ~wr_ptr_q;
			if (give)
				rd_ptr_q <= ~rd_ptr_q;
			case ({take, give})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign probe_index      = res_q[rd_ptr_q].probe_index;
	assign battery_level    = res_q[rd_ptr_q].battery_level;
	assign low_battery      = res_q[rd_ptr_q].low_battery;
	assign charge_mode      = res_q[rd_ptr_q].charge_mode;
	assign full_flag        = res_q[rd_ptr_q].full_flag;
	assign charge_qualified = res_q[rd_ptr_q].charge_qualified;

endmodule

// File: hw/rtl/blscc_checker.sv
// ----------------------------------------------------------------------------
// blscc_checker
// Port-level checks for the battery level scan and charge control unit.
// ----------------------------------------------------------------------------
module blscc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] probe_index,
	input logic [2:0] battery_level,
	input logic       low_battery,
	input logic [2:0] charge_mode,
	input logic       full_flag,
	input logic       charge_qualified
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(probe_index)
			&& $stable(battery_level) && $stable(charge_mode))
		else $error("stalled result changed");

	// An item accepted into an empty output shows a result next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("accepted item produced no result");

	// Full battery only while qualified, with charging off
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_flag |-> charge_qualified
			&& charge_mode == blscc_pkg::MODE_OFF)
		else $error("full flag without qualified off mode");

	// Low battery flag only at the empty level
	a_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && low_battery |-> battery_level == blscc_pkg::LEVEL_EMPTY)
		else $error("low battery flag at non-empty level");

endmodule

bind battery_level_scan_charge_control_unit blscc_checker u_blscc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.probe_index      (probe_index),
	.battery_level    (battery_level),
	.low_battery      (low_battery),
	.charge_mode      (charge_mode),
	.full_flag        (full_flag),
	.charge_qualified (charge_qualified)
);

// File: tb/battery_charge_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_charge_checker
// Watches the configuration, item and result channels of the battery level
// scan and charge control unit. It keeps its own copy of the scan and charge
// state, predicts one result per accepted item and compares each accepted
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module battery_charge_checker
	import blscc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic               below_threshold,
	input  logic               charger_present,
	input  logic               temp_high,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [PROBE_W-1:0] probe_index,
	input  logic [LEVEL_W-1:0] battery_level,
	input  logic               low_battery,
	input  logic [MODE_W-1:0]  charge_mode,
	input  logic               full_flag,
	input  logic               charge_qualified,
	output int                 errors,
	output int                 pending,
	output int                 checked
);

	// Results predicted but not yet seen on the output
	result_t status_q[$];

	// Shadow of the configuration
	logic [CFG_W-1:0] latch_after;
	logic [CFG_W-1:0] qualify_after;

	// Shadow of the scan and charge state
	logic [PROBE_W-1:0] scan_probe;
	logic [LEVEL_W-1:0] scan_seen;
	logic [COUNT_W-1:0] scan_run;
	logic [LEVEL_W-1:0] level_out;
	logic               empty_out;
	logic               charged_full;
	logic               charger_ok;
	logic [COUNT_W-1:0] tick_run;
	logic [MODE_W-1:0]  mode_out;

	// Apply one sample or tick to the shadow state and return the new status
	task automatic advance_battery_state(input item_t it, output result_t r);
		if (it.action == ACT_SAMPLE) begin
			if (!it.below_threshold) begin
				if (scan_probe == scan_seen)
					scan_run = (scan_run == COUNT_MAX) ? scan_run : scan_run + 1'b1;
				else
					scan_run = '0;
				scan_seen = scan_probe;
			end else if (scan_probe == PROBE_LOWEST) begin
				scan_run = (scan_run == COUNT_MAX) ? scan_run : scan_run + 1'b1;
				scan_seen = LEVEL_EMPTY;
			end else begin
				scan_run = '0;
				scan_probe = scan_probe + 1'b1;
			end
			if (scan_probe >= PROBE_COUNT)
				scan_probe = PROBE_TOP;
			// Latch the level once the run is long enough, restart the scan
			if (scan_run >= latch_after) begin
				scan_probe = PROBE_TOP;
				scan_run = '0;
				level_out = scan_seen;
				empty_out = (scan_seen == LEVEL_EMPTY);
			end
		end else if (!it.charger_present) begin
			mode_out = MODE_OFF;
			charged_full = 1'b0;
			charger_ok = 1'b0;
			tick_run = '0;
		end else if (charged_full) begin
			tick_run = '0;
		end else begin
			tick_run = tick_run + 1'b1;
			if (tick_run == qualify_after) begin
				charger_ok = 1'b1;
				tick_run = '0;
			end
			// Pick the charge mode from the latched level
			if (charger_ok) begin
				empty_out = 1'b0;
				case (level_out)
					LEVEL_FULL: begin
						charged_full = 1'b1;
						mode_out = MODE_OFF;
					end
					LEVEL_80MA:                  mode_out = MODE_80MA;
					LEVEL_HIGH_LO, LEVEL_HIGH_HI: mode_out = it.temp_high ? MODE_HIGH_REDUCED : MODE_HIGH;
					LEVEL_LOW, LEVEL_EMPTY:      mode_out = MODE_TRICKLE;
					default: ;
				endcase
			end
		end
		r.probe_index      = scan_probe;
		r.battery_level    = level_out;
		r.low_battery      = empty_out;
		r.charge_mode      = mode_out;
		r.full_flag        = charged_full;
		r.charge_qualified = charger_ok;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Track configuration, predict on each item, compare on each result
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		item_t   it;
		if (!arst_n) begin
			status_q.delete();
			latch_after   = DEBOUNCE_RESET;
			qualify_after = QUALIFY_RESET;
			scan_probe    = PROBE_TOP;
			scan_seen     = LEVEL_FULL;
			scan_run      = '0;
			level_out     = LEVEL_FULL;
			empty_out     = 1'b0;
			charged_full  = 1'b0;
			charger_ok    = 1'b0;
			tick_run      = '0;
			mode_out      = MODE_OFF;
			errors        = 0;
			pending       = 0;
			checked       = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{probe_index, battery_level, low_battery, charge_mode, full_flag,
					charge_qualified};
				if (status_q.size() == 0) begin
					$display("%0t ns: result with no item outstanding, expected none, got %h",
						$time, got);
					errors++;
				end else begin
					want = status_q.pop_front();
					check_field("probe_index", want.probe_index, got.probe_index);
					check_field("battery_level", want.battery_level, got.battery_level);
					check_field("low_battery", want.low_battery, got.low_battery);
					check_field("charge_mode", want.charge_mode, got.charge_mode);
					check_field("full_flag", want.full_flag, got.full_flag);
					check_field("charge_qualified", want.charge_qualified,
						got.charge_qualified);
					checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEBOUNCE_LIMIT: latch_after = cfg_data;
					CFG_QUALIFY_TICKS:  qualify_after = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				it = '{action, below_threshold, charger_present, temp_high};
				advance_battery_state(it, want);
				status_q.push_back(want);
			end
			pending = status_q.size();
		end
	end

endmodule

// File: tb/battery_level_scan_charge_control_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_level_scan_charge_control_unit_test
// Drives comparator samples and charge ticks into the unit under several
// debounce and qualify settings, with random gaps on both channels and one
// long result stall; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module battery_level_scan_charge_control_unit_test;
	import blscc_pkg::*;

	localparam int HOLD_CYCLES = 40;
	localparam int RUN_LIMIT   = 200000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic               below_threshold;
	logic               charger_present;
	logic               temp_high;
	logic               out_valid;
	logic               out_ready;
	logic [PROBE_W-1:0] probe_index;
	logic [LEVEL_W-1:0] battery_level;
	logic               low_battery;
	logic [MODE_W-1:0]  charge_mode;
	logic               full_flag;
	logic               charge_qualified;

	int   errors;
	int   pending;
	int   checked;
	int   cycle_count = 0;
	int   items_sent = 0;
	int   settings_used = 0;
	int   latch_setting = DEBOUNCE_RESET;
	int   qualify_setting = QUALIFY_RESET;
	int   tx_left = 0;
	logic tx_steady = 1'b0;
	logic hold_results = 1'b0;

	battery_level_scan_charge_control_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.below_threshold  (below_threshold),
		.charger_present  (charger_present),
		.temp_high        (temp_high),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.probe_index      (probe_index),
		.battery_level    (battery_level),
		.low_battery      (low_battery),
		.charge_mode      (charge_mode),
		.full_flag        (full_flag),
		.charge_qualified (charge_qualified)
	);

	battery_charge_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.below_threshold  (below_threshold),
		.charger_present  (charger_present),
		.temp_high        (temp_high),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.probe_index      (probe_index),
		.battery_level    (battery_level),
		.low_battery      (low_battery),
		.charge_mode      (charge_mode),
		.full_flag        (full_flag),
		.charge_qualified (charge_qualified),
		.errors           (errors),
		.pending          (pending),
		.checked          (checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Accept results with random stalls, stretches without stalls, one long hold
	initial begin : result_sink
		int   gap;
		int   left;
		logic steady;
		out_ready = 1'b0;
		left = 0;
		steady = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (left == 0) begin
				steady = ($urandom_range(0, 2) == 0);
				left = $urandom_range(8, 30);
			end
			left--;
			gap = steady ? 0 : $urandom_range(0, 3);
			if (hold_results) begin
				gap = HOLD_CYCLES;
				hold_results = 1'b0;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	// Offer one item after a random gap and hold it until taken
	task automatic offer(input item_t it);
		int gap;
		if (tx_left == 0) begin
			tx_steady = ($urandom_range(0, 2) == 0);
			tx_left = $urandom_range(8, 30);
		end
		tx_left--;
		gap = tx_steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		action          <= it.action;
		below_threshold <= it.below_threshold;
		charger_present <= it.charger_present;
		temp_high       <= it.temp_high;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic offer_fields(input logic act, input logic below, input logic chg,
		input logic temp);
		item_t it;
		it = '{act, below, chg, temp};
		offer(it);
	endtask

	// Stop sending and wait until every result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Send scan runs, tick runs and noise with random content
	task automatic random_items(input int count, input int hold_at);
		item_t burst[$];
		item_t it;
		int    sent;
		int    kind;
		int    steps;
		int    len;
		logic  drop_last;
		sent = 0;
		while (sent < count) begin
			burst.delete();
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				// step down a few thresholds, then settle on one
				steps = $urandom_range(0, 5);
				len = $urandom_range(0, 1) ? latch_setting + $urandom_range(0, 2)
					: $urandom_range(1, latch_setting);
				for (int n = 0; n < steps + len; n++) begin
					it.action = ACT_SAMPLE;
					it.below_threshold = (n < steps);
					it.charger_present = 1'($urandom_range(0, 1));
					it.temp_high = 1'($urandom_range(0, 1));
					burst.push_back(it);
				end
			end else if (kind < 85) begin
				// charger stays present, maybe pulled on the last tick
				len = $urandom_range(0, 1) ? qualify_setting + $urandom_range(0, 2)
					: $urandom_range(1, qualify_setting);
				drop_last = ($urandom_range(0, 9) < 3);
				for (int n = 0; n < len; n++) begin
					it.action = ACT_TICK;
					it.below_threshold = 1'($urandom_range(0, 1));
					it.charger_present = !(drop_last && n == len - 1);
					it.temp_high = 1'($urandom_range(0, 1));
					burst.push_back(it);
				end
			end else begin
				len = $urandom_range(1, 4);
				for (int n = 0; n < len; n++) begin
					it = item_t'(4'($urandom_range(0, 15)));
					burst.push_back(it);
				end
			end
			while (burst.size() != 0 && sent < count) begin
				it = burst.pop_front();
				offer(it);
				sent++;
				if (sent == hold_at)
					hold_results = 1'b1;
			end
		end
	endtask

	task automatic run_phase(input int latch_after, input int qualify_after, input int count,
		input int hold_at);
		drain_results();
		write_register(CFG_DEBOUNCE_LIMIT, CFG_W'(latch_after));
		write_register(CFG_QUALIFY_TICKS, CFG_W'(qualify_after));
		latch_setting = latch_after;
		qualify_setting = qualify_after;
		settings_used++;
		random_items(count, hold_at);
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_DEBOUNCE_LIMIT;
		cfg_data        = '0;
		in_valid        = 1'b0;
		action          = ACT_SAMPLE;
		below_threshold = 1'b0;
		charger_present = 1'b0;
		temp_high       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset limits: nothing latches or qualifies yet
		offer_fields(ACT_TICK, 1'b0, 1'b1, 1'b0);
		offer_fields(ACT_SAMPLE, 1'b0, 1'b0, 1'b1);
		offer_fields(ACT_TICK, 1'b1, 1'b0, 1'b1);

		// Single-sample latch and single-tick qualify
		run_phase(1, 1, 0, -1);
		// full level: qualify, report full, ignore ticks while full, charger pulled
		offer_fields(ACT_SAMPLE, 1'b0, 1'b0, 1'b0);
		offer_fields(ACT_TICK, 1'b0, 1'b1, 1'b0);
		offer_fields(ACT_TICK, 1'b1, 1'b1, 1'b1);
		offer_fields(ACT_TICK, 1'b0, 1'b0, 1'b0);
		// below every threshold: empty level, then trickle clears the low flag
		repeat (5) offer_fields(ACT_SAMPLE, 1'b1, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		offer_fields(ACT_TICK, 1'b0, 1'b1, 1'b1);
		// mid level: high current, reduced and plain, then charger pulled
		repeat (3) offer_fields(ACT_SAMPLE, 1'b1, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		repeat (2) offer_fields(ACT_SAMPLE, 1'b0, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		offer_fields(ACT_TICK, 1'b0, 1'b1, 1'b1);
		offer_fields(ACT_TICK, 1'b0, 1'b1, 1'b0);
		offer_fields(ACT_TICK, 1'b1, 1'b0, 1'b1);

		run_phase(3, 4, 120, 30);
		run_phase(255, 255, 300, -1);
		run_phase(1, 1, 80, -1);
		run_phase(2, 7, 40, -1);

		drain_results();
		repeat (4) @(negedge clk);

		$display("Covered %0d samples and charge ticks over %0d limit settings (1 to 255),",
			items_sent, settings_used + 1);
		$display("with %0d results compared and %0d mismatches", checked, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
